FILE: rtl/utf8_box_glue_segmenter_macros.svh
// assertion macros for the utf8 box and glue segmenter
`ifndef UTF8_BOX_GLUE_SEGMENTER_MACROS_SVH
`define UTF8_BOX_GLUE_SEGMENTER_MACROS_SVH

// same-cycle implication, held off during reset
`define UBGS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, held off during reset
`define UBGS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/ubgs_pkg.sv
// shared types, constants and classification functions for the segmenter
package ubgs_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_LATIN = 2'd0,
    KIND_CJK   = 2'd1,
    KIND_PUNCT = 2'd2,
    KIND_SPACE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    GLUE_NIL   = 2'd0,
    GLUE_LATIN = 2'd1,
    GLUE_MIXED = 2'd2,
    GLUE_CJK   = 2'd3
  } glue_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] length;
    kind_t       kind;
    glue_t       glue;
    logic [20:0] codepoint;
    logic        last;
    logic        too_long;
  } box_t;

  typedef struct packed {
    logic [1:0] count;
    box_t       box0;
    box_t       box1;
  } push_t;

  function automatic logic in_rng(logic [20:0] v, logic [20:0] lo, logic [20:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic kind_t class_of(logic [20:0] cp);
    kind_t k;
    if (cp == 21'h20 || cp == 21'h09 || cp == 21'h0A || cp == 21'h0D ||
        cp == 21'h00A0 || cp == 21'h3000) begin
      k = KIND_SPACE;
    end else if (in_rng(cp, 21'h3000, 21'h303F) || in_rng(cp, 21'hFF00, 21'hFF60) ||
                 cp == 21'h201C || cp == 21'h201D || cp == 21'h2018 ||
                 cp == 21'h2019) begin
      k = KIND_PUNCT;
    end else if (in_rng(cp, 21'h4E00, 21'h9FFF) || in_rng(cp, 21'h3400, 21'h4DBF) ||
                 in_rng(cp, 21'h20000, 21'h2A6DF) ||
                 in_rng(cp, 21'h2A700, 21'h2B81F) ||
                 in_rng(cp, 21'hF900, 21'hFAFF) || in_rng(cp, 21'h3000, 21'h30FF) ||
                 in_rng(cp, 21'hAC00, 21'hD7AF)) begin
      k = KIND_CJK;
    end else begin
      k = KIND_LATIN;
    end
    return k;
  endfunction

  function automatic glue_t glue_of(kind_t prev, kind_t cur);
    glue_t g;
    if (prev == KIND_SPACE || cur == KIND_SPACE) begin
      g = GLUE_NIL;
    end else if (prev == KIND_LATIN && cur == KIND_LATIN) begin
      g = GLUE_LATIN;
    end else if (prev != KIND_LATIN && cur != KIND_LATIN) begin
      g = GLUE_CJK;
    end else begin
      g = GLUE_MIXED;
    end
    return g;
  endfunction

endpackage

FILE: rtl/ubgs_core.sv
// utf8 decode, classification and box/glue generation for one byte per cycle while go is high
module ubgs_core #(
  parameter int POSITION_BITS = ubgs_pkg::POSITION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [7:0]    text_byte,
  input  logic          last_byte,
  output ubgs_pkg::push_t push
);
  import ubgs_pkg::*;

  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [1:0]               cont, cont_next;
  logic [20:0]              acc, acc_next;
  logic [POSITION_BITS-1:0] cstart, cstart_next;
  logic [2:0]               cbytes, cbytes_next;
  logic                     in_word, in_word_next;
  logic [POSITION_BITS-1:0] wstart, wstart_next;
  kind_t                    prev, prev_next;
  logic                     seen, seen_next;
  logic                     ovf, ovf_next;

  logic [1:0]               cont_dec;
  logic [20:0]              acc_dec;
  logic                     done;
  kind_t                    kind;
  logic                     emit_a, emit_b, emit_c;
  kind_t                    prev1;
  logic                     seen1;
  box_t                     box_a, box_b, box_c;

  function automatic logic [15:0] sat16(logic [POSITION_BITS-1:0] v);
    logic [15:0] r;
    if (v > POSITION_BITS'(17'h0FFFF)) begin
      r = 16'hFFFF;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  function automatic logic [15:0] len16(logic [POSITION_BITS-1:0] v);
    logic [15:0] r;
    r = sat16(v);
    if (r == 16'd0) begin
      r = 16'd1;
    end
    return r;
  endfunction

  always_comb begin
    ovf_next = ovf;
    pos_next = pos;
    if (pos == PosMax) begin
      ovf_next = 1'b1;
    end else begin
      pos_next = pos + 1'b1;
    end

    cstart_next = cstart;
    cbytes_next = cbytes;
    if (cont == 2'd0) begin
      cstart_next = pos;
      cbytes_next = 3'd1;
      if (text_byte[7:5] == 3'b110) begin
        acc_dec  = {16'd0, text_byte[4:0]};
        cont_dec = 2'd1;
      end else if (text_byte[7:4] == 4'b1110) begin
        acc_dec  = {17'd0, text_byte[3:0]};
        cont_dec = 2'd2;
      end else if (text_byte[7:3] == 5'b11110) begin
        acc_dec  = {18'd0, text_byte[2:0]};
        cont_dec = 2'd3;
      end else begin
        acc_dec  = {13'd0, text_byte};
        cont_dec = 2'd0;
      end
    end else begin
      acc_dec     = {acc[14:0], text_byte[5:0]};
      cont_dec    = cont - 2'd1;
      cbytes_next = cbytes + 3'd1;
    end

    acc_next  = acc_dec;
    cont_next = cont_dec;
    if (last_byte) begin
      cont_next = 2'd0;
      case (cont_dec)
        2'd1:    acc_next = {acc_dec[14:0], 6'd0};
        2'd2:    acc_next = {acc_dec[8:0], 12'd0};
        2'd3:    acc_next = {acc_dec[2:0], 18'd0};
        default: acc_next = acc_dec;
      endcase
    end

    done = (cont_next == 2'd0);
    kind = class_of(acc_next);

    emit_a = done && in_word && (kind != KIND_LATIN);
    emit_b = done && (kind != KIND_LATIN);

    in_word_next = in_word;
    wstart_next  = wstart;
    if (done) begin
      if (kind == KIND_LATIN) begin
        if (!in_word) begin
          wstart_next = cstart_next;
        end
        in_word_next = 1'b1;
      end else begin
        in_word_next = 1'b0;
      end
    end
    emit_c = last_byte && in_word_next;

    prev1 = emit_a ? KIND_LATIN : prev;
    seen1 = emit_a | seen;

    box_a.start     = sat16(wstart);
    box_a.length    = len16(cstart_next - wstart);
    box_a.kind      = KIND_LATIN;
    box_a.glue      = seen ? glue_of(prev, KIND_LATIN) : GLUE_NIL;
    box_a.codepoint = 21'd0;
    box_a.last      = 1'b0;
    box_a.too_long  = ovf_next;

    box_b.start     = sat16(cstart_next);
    box_b.length    = {13'd0, cbytes_next};
    box_b.kind      = kind;
    box_b.glue      = seen1 ? glue_of(prev1, kind) : GLUE_NIL;
    box_b.codepoint = acc_next;
    box_b.last      = last_byte;
    box_b.too_long  = ovf_next;

    box_c.start     = sat16(wstart_next);
    box_c.length    = len16(pos_next - wstart_next);
    box_c.kind      = KIND_LATIN;
    box_c.glue      = seen1 ? glue_of(prev1, KIND_LATIN) : GLUE_NIL;
    box_c.codepoint = 21'd0;
    box_c.last      = 1'b1;
    box_c.too_long  = ovf_next;

    push.count = {1'b0, emit_a} + {1'b0, emit_b} + {1'b0, emit_c};
    push.box0  = emit_a ? box_a : (emit_b ? box_b : box_c);
    push.box1  = emit_b ? box_b : box_c;
    if (emit_a && !emit_b) begin
      push.box0.last = last_byte;
    end

    prev_next = prev1;
    seen_next = seen1;
    if (emit_b) begin
      prev_next = kind;
      seen_next = 1'b1;
    end else if (emit_c) begin
      prev_next = KIND_LATIN;
      seen_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (go && last_byte)) begin
      pos     <= '0;
      cont    <= 2'd0;
      acc     <= 21'd0;
      cstart  <= '0;
      cbytes  <= 3'd0;
      in_word <= 1'b0;
      wstart  <= '0;
      prev    <= KIND_LATIN;
      seen    <= 1'b0;
      ovf     <= 1'b0;
    end else if (go) begin
      pos     <= pos_next;
      cont    <= cont_next;
      acc     <= acc_next;
      cstart  <= cstart_next;
      cbytes  <= cbytes_next;
      in_word <= in_word_next;
      wstart  <= wstart_next;
      prev    <= prev_next;
      seen    <= seen_next;
      ovf     <= ovf_next;
    end
  end

endmodule

FILE: rtl/ubgs_fifo.sv
// result queue taking up to two boxes per cycle and giving one
module ubgs_fifo (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  ubgs_pkg::push_t          push,
  input  logic                     rd_en,
  output ubgs_pkg::box_t           head,
  output logic                     not_empty,
  output logic [ubgs_pkg::QUEUE_AW:0] level
);
  import ubgs_pkg::*;

  box_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp, rp;
  logic [QUEUE_AW:0]   level_next;
  logic [1:0]          n_in;

  assign n_in       = wr_en ? push.count : 2'd0;
  assign level_next = level + (QUEUE_AW+1)'(n_in) - (QUEUE_AW+1)'(rd_en);
  assign head       = mem[rp];
  assign not_empty  = (level != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      wp    <= wp + QUEUE_AW'(n_in);
      rp    <= rp + QUEUE_AW'(rd_en);
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem[wp] <= push.box0;
    end
    if (n_in == 2'd2) begin
      mem[wp + 1'b1] <= push.box1;
    end
  end

endmodule

FILE: rtl/utf8_box_glue_segmenter.sv
// utf8 box and glue segmenter top level
// a byte transfer lands in the input register; its boxes are written into the output
// queue once go is high and are offered at the queue head in arrival order
// one byte per cycle while the four-entry output queue holds two or fewer boxes
// each byte yields at most two boxes, delivered one per cycle while box_stall is low
// synchronous active-high reset clears the decoder state and empties the queue
module utf8_box_glue_segmenter #(
  parameter int POSITION_BITS = ubgs_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  input  logic        last_byte,
  output logic        box_valid,
  input  logic        box_stall,
  output logic [15:0] box_start,
  output logic [15:0] box_length,
  output logic [1:0]  box_kind,
  output logic [1:0]  glue_kind,
  output logic [20:0] box_codepoint,
  output logic        last_box,
  output logic        too_long
);
  import ubgs_pkg::*;
  `include "utf8_box_glue_segmenter_macros.svh"

  logic              ivalid;
  logic [7:0]        ibyte;
  logic              ilast;
  logic              go;
  logic              load;
  push_t             push;
  box_t              head;
  logic [QUEUE_AW:0] level;
  logic              pop;

  assign go         = ivalid && (level <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
  assign text_stall = ivalid && !go;
  assign load       = text_valid && !text_stall;
  assign pop        = box_valid && !box_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (load) begin
      ivalid <= 1'b1;
    end else if (go) begin
      ivalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ibyte <= text_byte;
      ilast <= last_byte;
    end
  end

  ubgs_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .text_byte(ibyte),
    .last_byte(ilast),
    .push     (push)
  );

  ubgs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (go),
    .push     (push),
    .rd_en    (pop),
    .head     (head),
    .not_empty(box_valid),
    .level    (level)
  );

  assign box_start     = head.start;
  assign box_length    = head.length;
  assign box_kind      = head.kind;
  assign glue_kind     = head.glue;
  assign box_codepoint = head.codepoint;
  assign last_box      = head.last;
  assign too_long      = head.too_long;

  `UBGS_ASSERT_IMPL(a_level_bound, clk, rst, 1'b1, level <= (QUEUE_AW+1)'(QUEUE_DEPTH))
  `UBGS_ASSERT_IMPL(a_last_emits, clk, rst, go && ilast, push.count != 2'd0)
  `UBGS_ASSERT_IMPL(a_stall_held, clk, rst, text_stall, ivalid)
  `UBGS_ASSERT_IMPL(a_len_nonzero, clk, rst, box_valid, box_length != 16'd0)
  `UBGS_ASSERT_NEXT(a_push_shows, clk, rst, go && push.count != 2'd0, box_valid)

endmodule
